[src/tqpm_pkg.sv]
`default_nettype none

package tqpm_pkg;

   // result field widths and fixed formats
   localparam int WEIGHT_WIDTH   = 40;
   localparam int INDEX_WIDTH    = 4;
   localparam int COORD_FRAC     = 16;
   localparam int RULE_WIDTH     = 2;
   localparam int ROM_WIDTH      = 32;
   localparam int MAX_POINTS     = 9;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   // rule codes
   localparam logic [RULE_WIDTH-1:0] RULE_THREE = 2'd0;
   localparam logic [RULE_WIDTH-1:0] RULE_FOUR  = 2'd1;
   localparam logic [RULE_WIDTH-1:0] RULE_NINE  = 2'd2;
   localparam logic [RULE_WIDTH-1:0] RULE_NONE  = 2'd3;

   // register index (byte address bit 2 and up)
   localparam logic [0:0] REG_RULE_SELECT = 1'b0;

   // queue status seen by both sides of the job queue
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   // reference points and weights, Q0.32 rounded to nearest
   localparam logic [ROM_WIDTH-1:0] ROM_A [0:2][0:MAX_POINTS-1] = '{
      '{32'd2147483648, 32'd2147483648, 32'd0, 32'd0, 32'd0,
        32'd0, 32'd0, 32'd0, 32'd0},
      '{32'd3387333910, 32'd3387333910, 32'd907633386, 32'd907633386, 32'd0,
        32'd0, 32'd0, 32'd0, 32'd0},
      '{32'd2147483648, 32'd3810917329, 32'd3810917329, 32'd484049967,
        32'd484049967, 32'd2147483648, 32'd2147483648, 32'd3810917329,
        32'd484049967}
   };

   localparam logic [ROM_WIDTH-1:0] ROM_B [0:2][0:MAX_POINTS-1] = '{
      '{32'd0, 32'd2147483648, 32'd2147483648, 32'd0, 32'd0,
        32'd0, 32'd0, 32'd0, 32'd0},
      '{32'd715827883, 32'd191805503, 32'd2671506028, 32'd715827883, 32'd0,
        32'd0, 32'd0, 32'd0, 32'd0},
      '{32'd1073741824, 32'd429496730, 32'd54553237, 32'd3381420599,
        32'd429496730, 32'd1905458664, 32'd242024984, 32'd242024984,
        32'd1905458664}
   };

   localparam logic [ROM_WIDTH-1:0] ROM_W [0:2][0:MAX_POINTS-1] = '{
      '{32'd715827883, 32'd715827883, 32'd715827883, 32'd0, 32'd0,
        32'd0, 32'd0, 32'd0, 32'd0},
      '{32'd226908346, 32'd226908346, 32'd846833478, 32'd846833478, 32'd0,
        32'd0, 32'd0, 32'd0, 32'd0},
      '{32'd424194301, 32'd37349534, 32'd37349534, 32'd294052263,
        32'd294052263, 32'd265121438, 32'd265121438, 32'd59759255,
        32'd470483621}
   };

   function automatic logic [INDEX_WIDTH-1:0] rule_len(input logic [RULE_WIDTH-1:0] rule);
      logic [INDEX_WIDTH-1:0] n;
      case (rule)
         RULE_THREE: n = 4'd3;
         RULE_FOUR:  n = 4'd4;
         RULE_NINE:  n = 4'd9;
         default:    n = 4'd1;
      endcase
      return n;
   endfunction

   function automatic logic [ROM_WIDTH-1:0] rom_a(input logic [RULE_WIDTH-1:0] rule,
                                                   input logic [INDEX_WIDTH-1:0] idx);
      logic [ROM_WIDTH-1:0] v;
      v = '0;
      if (rule != RULE_NONE && idx < 4'(MAX_POINTS)) begin
         v = ROM_A[rule][idx];
      end
      return v;
   endfunction

   function automatic logic [ROM_WIDTH-1:0] rom_b(input logic [RULE_WIDTH-1:0] rule,
                                                   input logic [INDEX_WIDTH-1:0] idx);
      logic [ROM_WIDTH-1:0] v;
      v = '0;
      if (rule != RULE_NONE && idx < 4'(MAX_POINTS)) begin
         v = ROM_B[rule][idx];
      end
      return v;
   endfunction

   function automatic logic [ROM_WIDTH-1:0] rom_w(input logic [RULE_WIDTH-1:0] rule,
                                                   input logic [INDEX_WIDTH-1:0] idx);
      logic [ROM_WIDTH-1:0] v;
      v = '0;
      if (rule != RULE_NONE && idx < 4'(MAX_POINTS)) begin
         v = ROM_W[rule][idx];
      end
      return v;
   endfunction

endpackage

`default_nettype wire

[src/tqpm_front.sv]
`default_nettype none

module tqpm_front #(
   parameter int COORD_WIDTH = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic signed [COORD_WIDTH-1:0]       vertex0_x,
   input  wire logic signed [COORD_WIDTH-1:0]       vertex0_y,
   input  wire logic signed [COORD_WIDTH-1:0]       vertex1_x,
   input  wire logic signed [COORD_WIDTH-1:0]       vertex1_y,
   input  wire logic signed [COORD_WIDTH-1:0]       vertex2_x,
   input  wire logic signed [COORD_WIDTH-1:0]       vertex2_y,
   input  wire logic [tqpm_pkg::RULE_WIDTH-1:0]     rule_select,
   input  wire tqpm_pkg::qstat_type                 qstat,
   output logic                                     push,
   output logic [tqpm_pkg::RULE_WIDTH-1:0]          job_rule,
   output logic signed [COORD_WIDTH-1:0]            job_x0,
   output logic signed [COORD_WIDTH-1:0]            job_y0,
   output logic signed [COORD_WIDTH:0]              job_dx1,
   output logic signed [COORD_WIDTH:0]              job_dy1,
   output logic signed [COORD_WIDTH:0]              job_dx2,
   output logic signed [COORD_WIDTH:0]              job_dy2,
   output logic [63:0]                              job_jac,
   output logic                                     job_jbig
);

   localparam int CW = COORD_WIDTH;
   localparam int PW = 2 * CW + 2;
   localparam int JW = 2 * CW + 3;

   logic                                 en;
   logic                                 drop;
   logic [JW-1:0]                        jabs;

   // stage 1: edge vectors
   logic                                 f1_vld_ff, f1_vld_in;
   logic [tqpm_pkg::RULE_WIDTH-1:0]      f1_rule_ff, f1_rule_in;
   logic signed [CW-1:0]                 f1_x0_ff, f1_x0_in, f1_y0_ff, f1_y0_in;
   logic signed [CW:0]                   f1_dx1_ff, f1_dx1_in, f1_dy1_ff, f1_dy1_in;
   logic signed [CW:0]                   f1_dx2_ff, f1_dx2_in, f1_dy2_ff, f1_dy2_in;

   // stage 2: cross products
   logic                                 f2_vld_ff, f2_vld_in;
   logic [tqpm_pkg::RULE_WIDTH-1:0]      f2_rule_ff;
   logic signed [CW-1:0]                 f2_x0_ff, f2_y0_ff;
   logic signed [CW:0]                   f2_dx1_ff, f2_dy1_ff, f2_dx2_ff, f2_dy2_ff;
   logic signed [PW-1:0]                 f2_p1_ff, f2_p1_in, f2_p2_ff, f2_p2_in;

   // stage 3: signed determinant
   logic                                 f3_vld_ff, f3_vld_in;
   logic [tqpm_pkg::RULE_WIDTH-1:0]      f3_rule_ff;
   logic signed [CW-1:0]                 f3_x0_ff, f3_y0_ff;
   logic signed [CW:0]                   f3_dx1_ff, f3_dy1_ff, f3_dx2_ff, f3_dy2_ff;
   logic signed [JW-1:0]                 f3_jac_ff, f3_jac_in;

   // unused rule code: the triangle is taken and dropped here
   assign drop = f3_vld_ff && (f3_rule_ff == tqpm_pkg::RULE_NONE);
   assign en   = !f3_vld_ff || drop || !qstat.full;
   assign push = f3_vld_ff && !drop && !qstat.full;
   assign req_tready = en;

   assign f1_vld_in  = req_tvalid;
   assign f1_rule_in = rule_select;
   assign f1_x0_in   = vertex0_x;
   assign f1_y0_in   = vertex0_y;
   assign f1_dx1_in  = $signed({vertex1_x[CW-1], vertex1_x}) - $signed({vertex0_x[CW-1], vertex0_x});
   assign f1_dy1_in  = $signed({vertex1_y[CW-1], vertex1_y}) - $signed({vertex0_y[CW-1], vertex0_y});
   assign f1_dx2_in  = $signed({vertex2_x[CW-1], vertex2_x}) - $signed({vertex0_x[CW-1], vertex0_x});
   assign f1_dy2_in  = $signed({vertex2_y[CW-1], vertex2_y}) - $signed({vertex0_y[CW-1], vertex0_y});

   assign f2_vld_in = f1_vld_ff;
   assign f2_p1_in  = f1_dx1_ff * f1_dy2_ff;
   assign f2_p2_in  = f1_dx2_ff * f1_dy1_ff;

   assign f3_vld_in = f2_vld_ff;
   assign f3_jac_in = $signed({f2_p1_ff[PW-1], f2_p1_ff}) - $signed({f2_p2_ff[PW-1], f2_p2_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_vld_ff <= 1'b0;
         f2_vld_ff <= 1'b0;
         f3_vld_ff <= 1'b0;
      end else if (en) begin
         f1_vld_ff <= f1_vld_in;
         f2_vld_ff <= f2_vld_in;
         f3_vld_ff <= f3_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f1_rule_ff <= f1_rule_in;
         f1_x0_ff   <= f1_x0_in;
         f1_y0_ff   <= f1_y0_in;
         f1_dx1_ff  <= f1_dx1_in;
         f1_dy1_ff  <= f1_dy1_in;
         f1_dx2_ff  <= f1_dx2_in;
         f1_dy2_ff  <= f1_dy2_in;

         f2_rule_ff <= f1_rule_ff;
         f2_x0_ff   <= f1_x0_ff;
         f2_y0_ff   <= f1_y0_ff;
         f2_dx1_ff  <= f1_dx1_ff;
         f2_dy1_ff  <= f1_dy1_ff;
         f2_dx2_ff  <= f1_dx2_ff;
         f2_dy2_ff  <= f1_dy2_ff;
         f2_p1_ff   <= f2_p1_in;
         f2_p2_ff   <= f2_p2_in;

         f3_rule_ff <= f2_rule_ff;
         f3_x0_ff   <= f2_x0_ff;
         f3_y0_ff   <= f2_y0_ff;
         f3_dx1_ff  <= f2_dx1_ff;
         f3_dy1_ff  <= f2_dy1_ff;
         f3_dx2_ff  <= f2_dx2_ff;
         f3_dy2_ff  <= f2_dy2_ff;
         f3_jac_ff  <= f3_jac_in;
      end
   end

   // absolute determinant; anything at or above 2^64 saturates the weight
   assign jabs     = f3_jac_ff[JW-1] ? JW'(-f3_jac_ff) : JW'(f3_jac_ff);
   assign job_jac  = 64'(jabs);
   assign job_jbig = |(jabs >> 64);

   assign job_rule = f3_rule_ff;
   assign job_x0   = f3_x0_ff;
   assign job_y0   = f3_y0_ff;
   assign job_dx1  = f3_dx1_ff;
   assign job_dy1  = f3_dy1_ff;
   assign job_dx2  = f3_dx2_ff;
   assign job_dy2  = f3_dy2_ff;

endmodule

`default_nettype wire

[src/tqpm_queue.sv]
`default_nettype none

module tqpm_queue #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      rdata,
   output tqpm_pkg::qstat_type   qstat
);

   // two entries, one being drained while the next is filled
   logic [WIDTH-1:0] mem_ff [0:1];
   logic             wptr_ff, wptr_in;
   logic             rptr_ff, rptr_in;
   logic [1:0]       count_ff, count_in;

   assign wptr_in  = push ? !wptr_ff : wptr_ff;
   assign rptr_in  = pop ? !rptr_ff : rptr_ff;
   assign count_in = count_ff + 2'(push) - 2'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= wdata;
      end
   end

   assign rdata       = mem_ff[rptr_ff];
   assign qstat.full  = count_ff == 2'd2;
   assign qstat.empty = count_ff == 2'd0;

endmodule

`default_nettype wire

[src/tqpm_back.sv]
`default_nettype none

module tqpm_back #(
   parameter int COORD_WIDTH     = 32,
   parameter int TABLE_FRAC_BITS = 24
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire tqpm_pkg::qstat_type                  qstat,
   output logic                                      pop,
   input  wire logic [tqpm_pkg::RULE_WIDTH-1:0]      job_rule,
   input  wire logic signed [COORD_WIDTH-1:0]        job_x0,
   input  wire logic signed [COORD_WIDTH-1:0]        job_y0,
   input  wire logic signed [COORD_WIDTH:0]          job_dx1,
   input  wire logic signed [COORD_WIDTH:0]          job_dy1,
   input  wire logic signed [COORD_WIDTH:0]          job_dx2,
   input  wire logic signed [COORD_WIDTH:0]          job_dy2,
   input  wire logic [63:0]                          job_jac,
   input  wire logic                                 job_jbig,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic signed [COORD_WIDTH-1:0]             point_x,
   output logic signed [COORD_WIDTH-1:0]             point_y,
   output logic [tqpm_pkg::WEIGHT_WIDTH-1:0]         weight,
   output logic [tqpm_pkg::INDEX_WIDTH-1:0]          point_index,
   output logic                                      last_point
);

   localparam int CW  = COORD_WIDTH;
   localparam int F   = TABLE_FRAC_BITS;
   localparam int IW  = tqpm_pkg::INDEX_WIDTH;
   localparam int WW  = tqpm_pkg::WEIGHT_WIDTH;
   localparam int SH  = tqpm_pkg::ROM_WIDTH - F;
   localparam int PW  = CW + F + 2;
   localparam int AW  = CW + F + 4;
   localparam int HW  = CW + 4;
   localparam int MW  = 32 + F;
   localparam int WPW = 65 + F;
   localparam int QW  = WPW - F - tqpm_pkg::COORD_FRAC;
   localparam logic [32:0]     ROM_HALF  = (33'd1 << SH) >> 1;
   localparam logic [AW-1:0]   RND_COORD = AW'(1) << (F - 1);
   localparam logic [WPW-1:0]  RND_WGT   = WPW'(1) << (F + tqpm_pkg::COORD_FRAC - 1);
   localparam logic [WW-1:0]   WGT_MAX   = '1;

   function automatic logic [CW-1:0] map_coord(input logic [CW-1:0] p0,
                                               input logic [PW-1:0] m1,
                                               input logic [PW-1:0] m2);
      logic [AW-1:0] acc;
      logic [HW-1:0] hi;
      logic          fits;
      acc  = {{4{p0[CW-1]}}, p0, {F{1'b0}}} + {{2{m1[PW-1]}}, m1}
           + {{2{m2[PW-1]}}, m2} + RND_COORD;
      hi   = acc[AW-1:F];
      fits = (hi[HW-1:CW-1] == '0) || (hi[HW-1:CW-1] == '1);
      if (fits) begin
         return hi[CW-1:0];
      end
      return hi[HW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
   endfunction

   function automatic logic [F-1:0] rom_round(input logic [31:0] v);
      logic [32:0] t;
      t = {1'b0, v} + ROM_HALF;
      return F'(t >> SH);
   endfunction

   logic                 en;
   logic                 issue;
   logic                 is_last;
   logic [IW-1:0]        npts;
   logic [IW-1:0]        idx_ff, idx_in;

   // stage 1: table values for the issued point
   logic                 s1_vld_ff, s1_vld_in;
   logic signed [CW-1:0] s1_x0_ff, s1_y0_ff;
   logic signed [CW:0]   s1_dx1_ff, s1_dy1_ff, s1_dx2_ff, s1_dy2_ff;
   logic [63:0]          s1_jac_ff;
   logic                 s1_jbig_ff;
   logic [F-1:0]         s1_a_ff, s1_a_in, s1_b_ff, s1_b_in, s1_w_ff, s1_w_in;
   logic [IW-1:0]        s1_idx_ff;
   logic                 s1_last_ff;

   // stage 2: products
   logic                 s2_vld_ff;
   logic signed [CW-1:0] s2_x0_ff, s2_y0_ff;
   logic signed [PW-1:0] s2_px1_ff, s2_px1_in, s2_px2_ff, s2_px2_in;
   logic signed [PW-1:0] s2_py1_ff, s2_py1_in, s2_py2_ff, s2_py2_in;
   logic [MW-1:0]        s2_wl_ff, s2_wl_in, s2_wh_ff, s2_wh_in;
   logic                 s2_jbig_ff, s2_wnz_ff;
   logic [IW-1:0]        s2_idx_ff;
   logic                 s2_last_ff;

   // output register
   logic                 out_vld_ff;
   logic [CW-1:0]        out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic [WW-1:0]        out_w_ff, out_w_in;
   logic [IW-1:0]        out_idx_ff;
   logic                 out_last_ff;
   logic [WPW-1:0]       wsum;
   logic [QW-1:0]        wq;

   assign en      = !out_vld_ff || rsp_tready;
   assign npts    = tqpm_pkg::rule_len(job_rule);
   assign is_last = idx_ff == npts - IW'(1);
   assign issue   = en && !qstat.empty;
   assign pop     = issue && is_last;
   assign idx_in  = issue ? (is_last ? '0 : idx_ff + IW'(1)) : idx_ff;

   assign s1_vld_in = issue;
   assign s1_a_in   = rom_round(tqpm_pkg::rom_a(job_rule, idx_ff));
   assign s1_b_in   = rom_round(tqpm_pkg::rom_b(job_rule, idx_ff));
   assign s1_w_in   = rom_round(tqpm_pkg::rom_w(job_rule, idx_ff));

   assign s2_px1_in = s1_dx1_ff * $signed({1'b0, s1_a_ff});
   assign s2_px2_in = s1_dx2_ff * $signed({1'b0, s1_b_ff});
   assign s2_py1_in = s1_dy1_ff * $signed({1'b0, s1_a_ff});
   assign s2_py2_in = s1_dy2_ff * $signed({1'b0, s1_b_ff});
   assign s2_wl_in  = s1_jac_ff[31:0] * s1_w_ff;
   assign s2_wh_in  = s1_jac_ff[63:32] * s1_w_ff;

   assign out_x_in = map_coord(s2_x0_ff, s2_px1_ff, s2_px2_ff);
   assign out_y_in = map_coord(s2_y0_ff, s2_py1_ff, s2_py2_ff);
   assign wsum     = {1'b0, s2_wh_ff, 32'd0} + WPW'(s2_wl_ff) + RND_WGT;
   assign wq       = wsum[WPW-1:F+tqpm_pkg::COORD_FRAC];

   always_comb begin
      if (s2_jbig_ff) begin
         out_w_in = s2_wnz_ff ? WGT_MAX : '0;
      end else if (|(wq >> WW)) begin
         out_w_in = WGT_MAX;
      end else begin
         out_w_in = wq[WW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff     <= '0;
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         if (en) begin
            s1_vld_ff  <= s1_vld_in;
            s2_vld_ff  <= s1_vld_ff;
            out_vld_ff <= s2_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_x0_ff    <= job_x0;
         s1_y0_ff    <= job_y0;
         s1_dx1_ff   <= job_dx1;
         s1_dy1_ff   <= job_dy1;
         s1_dx2_ff   <= job_dx2;
         s1_dy2_ff   <= job_dy2;
         s1_jac_ff   <= job_jac;
         s1_jbig_ff  <= job_jbig;
         s1_a_ff     <= s1_a_in;
         s1_b_ff     <= s1_b_in;
         s1_w_ff     <= s1_w_in;
         s1_idx_ff   <= idx_ff;
         s1_last_ff  <= is_last;

         s2_x0_ff    <= s1_x0_ff;
         s2_y0_ff    <= s1_y0_ff;
         s2_px1_ff   <= s2_px1_in;
         s2_px2_ff   <= s2_px2_in;
         s2_py1_ff   <= s2_py1_in;
         s2_py2_ff   <= s2_py2_in;
         s2_wl_ff    <= s2_wl_in;
         s2_wh_ff    <= s2_wh_in;
         s2_jbig_ff  <= s1_jbig_ff;
         s2_wnz_ff   <= |s1_w_ff;
         s2_idx_ff   <= s1_idx_ff;
         s2_last_ff  <= s1_last_ff;

         out_x_ff    <= out_x_in;
         out_y_ff    <= out_y_in;
         out_w_ff    <= out_w_in;
         out_idx_ff  <= s2_idx_ff;
         out_last_ff <= s2_last_ff;
      end
   end

   assign rsp_tvalid  = out_vld_ff;
   assign point_x     = out_x_ff;
   assign point_y     = out_y_ff;
   assign weight      = out_w_ff;
   assign point_index = out_idx_ff;
   assign last_point  = out_last_ff;

endmodule

`default_nettype wire

[src/triangle_quadrature_point_mapper.sv]
`default_nettype none

// channel  | dir | beat contents
// ---------+-----+-------------------------------------------------------------
// req_     | in  | one triangle: six signed Q16.16 vertex coordinates
// rsp_     | out | one quadrature point: mapped x, y, scaled weight, index, last
// csr_     | in  | rule_select register at byte address 0
//
// the front end takes one triangle per cycle unless the job queue is full,
// and forms the determinant in three stages; the back end then issues one
// point per cycle from the table while a job is queued and rsp_ is not
// stalled, so a triangle gives 3, 4 or 9 points (those of the selected rule).
// a two-entry job queue between them lets the front take the next triangles
// while the back end is still working or rsp_ is stalled.
// reset is synchronous; it empties the pipelines and queue and sets rule 0.
module triangle_quadrature_point_mapper #(
   parameter int COORD_WIDTH     = 32,
   parameter int TABLE_FRAC_BITS = 24
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,

   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // vertex0_x, vertex0_y, vertex1_x, vertex1_y, vertex2_x, vertex2_y
   input  wire logic [((6*COORD_WIDTH+7)/8)*8-1:0]   req_tdata,

   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // point_x, point_y, weight, point_index
   output logic [((2*COORD_WIDTH+tqpm_pkg::WEIGHT_WIDTH+tqpm_pkg::INDEX_WIDTH+7)/8)*8-1:0]
                                                     rsp_tdata,
   output logic                                      rsp_tlast,

   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [tqpm_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  wire logic [tqpm_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [tqpm_pkg::CSR_DATA_WIDTH-1:0]       csr_prdata,
   output logic                                      csr_pready
);

   localparam int CW    = COORD_WIDTH;
   localparam int RW    = tqpm_pkg::RULE_WIDTH;
   localparam int RSP_W = ((2*CW+tqpm_pkg::WEIGHT_WIDTH+tqpm_pkg::INDEX_WIDTH+7)/8)*8;
   localparam int JOB_W = RW + 1 + 64 + 4 * (CW + 1) + 2 * CW;

   // configuration register
   logic [RW-1:0] rule_select_ff, rule_select_in;
   logic          csr_wr;
   logic          csr_hit;

   assign csr_pready = 1'b1;
   assign csr_hit    = csr_paddr[2] == tqpm_pkg::REG_RULE_SELECT;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit;
   assign rule_select_in = csr_wr ? csr_pwdata[RW-1:0] : rule_select_ff;
   assign csr_prdata = csr_hit ? tqpm_pkg::CSR_DATA_WIDTH'(rule_select_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rule_select_ff <= tqpm_pkg::RULE_THREE;
      end else begin
         rule_select_ff <= rule_select_in;
      end
   end

   // front end to queue
   tqpm_pkg::qstat_type  qstat;
   logic                 push;
   logic                 pop;
   logic [RW-1:0]        f_rule, q_rule;
   logic signed [CW-1:0] f_x0, f_y0, q_x0, q_y0;
   logic signed [CW:0]   f_dx1, f_dy1, f_dx2, f_dy2;
   logic signed [CW:0]   q_dx1, q_dy1, q_dx2, q_dy2;
   logic [63:0]          f_jac, q_jac;
   logic                 f_jbig, q_jbig;
   logic [JOB_W-1:0]     q_rdata;

   logic [CW-1:0]                        rsp_x, rsp_y;
   logic [tqpm_pkg::WEIGHT_WIDTH-1:0]    rsp_weight;
   logic [tqpm_pkg::INDEX_WIDTH-1:0]     rsp_index;

   tqpm_front #(
      .COORD_WIDTH (CW)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .vertex0_x   (req_tdata[0*CW +: CW]),
      .vertex0_y   (req_tdata[1*CW +: CW]),
      .vertex1_x   (req_tdata[2*CW +: CW]),
      .vertex1_y   (req_tdata[3*CW +: CW]),
      .vertex2_x   (req_tdata[4*CW +: CW]),
      .vertex2_y   (req_tdata[5*CW +: CW]),
      .rule_select (rule_select_ff),
      .qstat       (qstat),
      .push        (push),
      .job_rule    (f_rule),
      .job_x0      (f_x0),
      .job_y0      (f_y0),
      .job_dx1     (f_dx1),
      .job_dy1     (f_dy1),
      .job_dx2     (f_dx2),
      .job_dy2     (f_dy2),
      .job_jac     (f_jac),
      .job_jbig    (f_jbig)
   );

   tqpm_queue #(
      .WIDTH (JOB_W)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .wdata ({f_rule, f_jbig, f_jac, f_dy2, f_dx2, f_dy1, f_dx1, f_y0, f_x0}),
      .pop   (pop),
      .rdata (q_rdata),
      .qstat (qstat)
   );

   assign {q_rule, q_jbig, q_jac, q_dy2, q_dx2, q_dy1, q_dx1, q_y0, q_x0} = q_rdata;

   tqpm_back #(
      .COORD_WIDTH     (CW),
      .TABLE_FRAC_BITS (TABLE_FRAC_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .qstat       (qstat),
      .pop         (pop),
      .job_rule    (q_rule),
      .job_x0      (q_x0),
      .job_y0      (q_y0),
      .job_dx1     (q_dx1),
      .job_dy1     (q_dy1),
      .job_dx2     (q_dx2),
      .job_dy2     (q_dy2),
      .job_jac     (q_jac),
      .job_jbig    (q_jbig),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .point_x     (rsp_x),
      .point_y     (rsp_y),
      .weight      (rsp_weight),
      .point_index (rsp_index),
      .last_point  (rsp_tlast)
   );

   assign rsp_tdata = RSP_W'({rsp_index, rsp_weight, rsp_y, rsp_x});

   // the front never writes into a full queue
   assert property (@(posedge clock) disable iff (reset) !(push && qstat.full))
      else $error("job pushed into full queue");

   // the back end never releases a job that is not there
   assert property (@(posedge clock) disable iff (reset) !(pop && qstat.empty))
      else $error("job popped from empty queue");

   // the last beat of a run carries the final index of the rule
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |->
         rsp_index == tqpm_pkg::rule_len(rule_select_ff) - tqpm_pkg::INDEX_WIDTH'(1))
      else $error("last beat with wrong point index");

   // the unused rule code gives no result beats
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rule_select_ff != tqpm_pkg::RULE_NONE)
      else $error("result beat under unused rule code");

endmodule

`default_nettype wire
